// File: hdl/arprfm_pkg.sv
// ----------------------------------------------------------------------------
// arprfm_pkg
// Shared constants and types for the ARP reply frame matcher.
// ----------------------------------------------------------------------------
package arprfm_pkg;

	localparam int unsigned POS_W    = 6;
	localparam int unsigned MAC_W    = 48;
	localparam int unsigned IP_W     = 32;
	localparam int unsigned BYTE_W   = 8;

	// Ethernet header plus ARP payload for IPv4
	localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(14 + 28);

	// Byte offsets within the frame
	localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
	localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
	localparam logic [POS_W-1:0] POS_HTYPE_HI = POS_W'(14);
	localparam logic [POS_W-1:0] POS_HTYPE_LO = POS_W'(15);
	localparam logic [POS_W-1:0] POS_PTYPE_HI = POS_W'(16);
	localparam logic [POS_W-1:0] POS_PTYPE_LO = POS_W'(17);
	localparam logic [POS_W-1:0] POS_OPER_HI  = POS_W'(20);
	localparam logic [POS_W-1:0] POS_OPER_LO  = POS_W'(21);
	localparam logic [POS_W-1:0] POS_SHA_FIRST = POS_W'(22);
	localparam logic [POS_W-1:0] POS_SHA_LAST  = POS_W'(27);
	localparam logic [POS_W-1:0] POS_SPA_0 = POS_W'(28);
	localparam logic [POS_W-1:0] POS_SPA_1 = POS_W'(29);
	localparam logic [POS_W-1:0] POS_SPA_2 = POS_W'(30);
	localparam logic [POS_W-1:0] POS_SPA_3 = POS_W'(31);

	// Required field values
	localparam logic [BYTE_W-1:0] ETYPE_ARP_HI  = 8'h08;
	localparam logic [BYTE_W-1:0] ETYPE_ARP_LO  = 8'h06;
	localparam logic [BYTE_W-1:0] HTYPE_ETH_HI  = 8'h00;
	localparam logic [BYTE_W-1:0] HTYPE_ETH_LO  = 8'h01;
	localparam logic [BYTE_W-1:0] PTYPE_IP4_HI  = 8'h08;
	localparam logic [BYTE_W-1:0] PTYPE_IP4_LO  = 8'h00;
	localparam logic [BYTE_W-1:0] OPER_REPLY_HI = 8'h00;
	localparam logic [BYTE_W-1:0] OPER_REPLY_LO = 8'h02;

	localparam logic [IP_W-1:0] GATEWAY_IP_RESET = 32'h0A00_0202;

	typedef struct packed {
		logic             is_reply;
		logic [MAC_W-1:0] sender_mac;
	} result_t;

endpackage

// File: hdl/arprfm_parse.sv
// ----------------------------------------------------------------------------
// arprfm_parse
// Per-frame parse state: byte position, match flag and captured sender MAC.
// Produces the frame result from the byte held in the input register.
// ----------------------------------------------------------------------------
module arprfm_parse (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [arprfm_pkg::BYTE_W-1:0]   data_byte_s1,
	input  logic                            frame_end_s1,
	input  logic [arprfm_pkg::IP_W-1:0]     gateway_ip,
	output arprfm_pkg::result_t             result
);

	logic [arprfm_pkg::POS_W-1:0] pos_q;
	logic                         ok_q;
	logic [arprfm_pkg::MAC_W-1:0] mac_q;

	logic [arprfm_pkg::POS_W-1:0] pos_next;
	logic                         ok_next;
	logic [arprfm_pkg::MAC_W-1:0] mac_next;
	logic                         byte_ok;
	logic                         in_frame;
	logic                         match;

	assign in_frame = pos_q < arprfm_pkg::FRAME_LEN;

	always_comb begin
		case (pos_q)
			arprfm_pkg::POS_ETYPE_HI: byte_ok = data_byte_s1 == arprfm_pkg::ETYPE_ARP_HI;
			arprfm_pkg::POS_ETYPE_LO: byte_ok = data_byte_s1 == arprfm_pkg::ETYPE_ARP_LO;
			arprfm_pkg::POS_HTYPE_HI: byte_ok = data_byte_s1 == arprfm_pkg::HTYPE_ETH_HI;
			arprfm_pkg::POS_HTYPE_LO: byte_ok = data_byte_s1 == arprfm_pkg::HTYPE_ETH_LO;
			arprfm_pkg::POS_PTYPE_HI: byte_ok = data_byte_s1 == arprfm_pkg::PTYPE_IP4_HI;
			arprfm_pkg::POS_PTYPE_LO: byte_ok = data_byte_s1 == arprfm_pkg::PTYPE_IP4_LO;
			arprfm_pkg::POS_OPER_HI:  byte_ok = data_byte_s1 == arprfm_pkg::OPER_REPLY_HI;
			arprfm_pkg::POS_OPER_LO:  byte_ok = data_byte_s1 == arprfm_pkg::OPER_REPLY_LO;
			arprfm_pkg::POS_SPA_0:    byte_ok = data_byte_s1 == gateway_ip[31:24];
			arprfm_pkg::POS_SPA_1:    byte_ok = data_byte_s1 == gateway_ip[23:16];
			arprfm_pkg::POS_SPA_2:    byte_ok = data_byte_s1 == gateway_ip[15:8];
			arprfm_pkg::POS_SPA_3:    byte_ok = data_byte_s1 == gateway_ip[7:0];
			default:                  byte_ok = 1'b1;
		endcase
	end

	always_comb begin
		pos_next = pos_q;
		ok_next  = ok_q;
		mac_next = mac_q;
		if (in_frame) begin
			pos_next = pos_q + 1'b1;
			ok_next  = ok_q & byte_ok;
			if (pos_q >= arprfm_pkg::POS_SHA_FIRST && pos_q <= arprfm_pkg::POS_SHA_LAST) begin
				mac_next = {mac_q[arprfm_pkg::MAC_W-arprfm_pkg::BYTE_W-1:0], data_byte_s1};
			end
		end
	end

	// Position saturates at the frame length, so equality means full length
	assign match = ok_next && (pos_next == arprfm_pkg::FRAME_LEN);

	assign result.is_reply   = match;
	assign result.sender_mac = match ? mac_next : '0;

	// Rearm on the last byte of every frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ok_q  <= 1'b1;
			mac_q <= '0;
		end else if (advance) begin
			if (frame_end_s1) begin
				pos_q <= '0;
				ok_q  <= 1'b1;
				mac_q <= '0;
			end else begin
				pos_q <= pos_next;
				ok_q  <= ok_next;
				mac_q <= mac_next;
			end
		end
	end

endmodule

// File: hdl/arprfm_out.sv
// ----------------------------------------------------------------------------
// arprfm_out
// Result register: holds one frame result until the downstream takes it.
// ----------------------------------------------------------------------------
module arprfm_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  arprfm_pkg::result_t result,
	output logic                slot_free,
	output logic                out_valid,
	input  logic                out_ready,
	output arprfm_pkg::result_t out_result
);

	logic                valid_q;
	arprfm_pkg::result_t result_q;

	assign slot_free  = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// File: hdl/arp_reply_frame_matcher.sv
// Path: the result reaches m_axis after the last byte has passed the input register
// and the result register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two sides, so only a full result register that is not drained
// stalls a last byte.
// Reset: arst_n clears the parse state, valid flags and restores gateway_ip to 10.0.2.2.
// ----------------------------------------------------------------------------
// arp_reply_frame_matcher
// Flags ARP replies from the configured IPv4 gateway and returns the sender MAC.
// ----------------------------------------------------------------------------
module arp_reply_frame_matcher (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write: gateway_ip
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [arprfm_pkg::IP_W-1:0]       cfg_data,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
	input  logic                              s_axis_tlast,   // frame_end
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [47:0]                       m_axis_tdata,   // [47:0] sender_mac
	output logic [0:0]                        m_axis_tuser    // [0] is_reply
);

	logic [arprfm_pkg::IP_W-1:0]   gateway_ip_q;
	logic                          valid_s1;
	logic [arprfm_pkg::BYTE_W-1:0] data_byte_s1;
	logic                          frame_end_s1;
	logic                          advance;
	logic                          slot_free;
	logic                          load;
	arprfm_pkg::result_t           result;
	arprfm_pkg::result_t           out_result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gateway_ip_q <= arprfm_pkg::GATEWAY_IP_RESET;
		end else if (cfg_valid) begin
			gateway_ip_q <= cfg_data;
		end
	end

	// Non-final bytes always drain; a last byte needs room in the result register
	assign advance       = valid_s1 && (!frame_end_s1 || slot_free);
	assign load          = advance && frame_end_s1;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_byte_s1 <= s_axis_tdata;
			frame_end_s1 <= s_axis_tlast;
		end
	end

	arprfm_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.data_byte_s1 (data_byte_s1),
		.frame_end_s1 (frame_end_s1),
		.gateway_ip   (gateway_ip_q),
		.result       (result)
	);

	arprfm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.result     (result),
		.slot_free  (slot_free),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata    = out_result.sender_mac;
	assign m_axis_tuser[0] = out_result.is_reply;

endmodule
